### rtl/core/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Differential drive odometry package
// Shared constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int POS_WIDTH_DEF  = 48;
    localparam int TRIG_BITS_DEF  = 16;
    localparam int CORDIC_FRAC    = 30;
    localparam int CORDIC_W       = 34;
    localparam logic [31:0] FWD_GAIN_RESET = 32'd183161;
    localparam logic [31:0] ROT_GAIN_RESET = 32'd253489;
    localparam logic [CORDIC_W-1:0] CORDIC_K = 34'sd652032874;

    localparam logic REG_FWD_GAIN = 1'b0;
    localparam logic REG_ROT_GAIN = 1'b1;

    // Queue entry from the front part: the count sum and difference.
    typedef struct packed {
        logic signed [16:0] dsum;
        logic signed [16:0] ddif;
    } ddo_cmd_t;

    function automatic logic [31:0] atan_lookup(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/ddo_front.sv
// ----------------------------------------------------------------------------
// Odometry front end
// Accepts encoder beats and forms the wrapped count sum and difference.
// ----------------------------------------------------------------------------
module ddo_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       right_count,
    input  logic [15:0]       left_count,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output ddo_pkg::ddo_cmd_t cmd
);

    logic [15:0] prev_right_reg;
    logic [15:0] prev_left_reg;
    logic        started_reg;
    logic signed [15:0] d_r;
    logic signed [15:0] d_l;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;

    always_comb begin
        d_r = started_reg ? $signed(right_count - prev_right_reg) : 16'sd0;
        d_l = started_reg ? $signed(left_count - prev_left_reg) : 16'sd0;
        cmd.dsum = 17'(d_r) + 17'(d_l);
        cmd.ddif = 17'(d_r) - 17'(d_l);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg    <= 1'b0;
            prev_right_reg <= '0;
            prev_left_reg  <= '0;
        end else if (in_valid && cmd_ready) begin
            started_reg    <= 1'b1;
            prev_right_reg <= right_count;
            prev_left_reg  <= left_count;
        end
    end

endmodule

### rtl/core/ddo_queue.sv
// ----------------------------------------------------------------------------
// Odometry command queue
// Two-entry queue between the front end and the pose engine.
// ----------------------------------------------------------------------------
module ddo_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  ddo_pkg::ddo_cmd_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output ddo_pkg::ddo_cmd_t rd_data
);

    ddo_pkg::ddo_cmd_t mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (do_wr) begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_rd) begin
                rptr_reg <= ~rptr_reg;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/core/ddo_back.sv
// ----------------------------------------------------------------------------
// Odometry pose engine
// Scales counts by the gains, runs an iterative CORDIC on the mid-step heading
// and accumulates the saturated position and the wrapped heading.
// ----------------------------------------------------------------------------
module ddo_back #(
    parameter int POS_WIDTH = ddo_pkg::POS_WIDTH_DEF,
    parameter int TRIG_BITS = ddo_pkg::TRIG_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  ddo_pkg::ddo_cmd_t           cmd,
    input  logic [31:0]                 forward_gain,
    input  logic [31:0]                 rotate_gain,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic signed [POS_WIDTH-1:0] pos_x,
    output logic signed [POS_WIDTH-1:0] pos_y,
    output logic signed [31:0]          heading
);

    localparam int CW    = ddo_pkg::CORDIC_W;
    localparam int SH    = ddo_pkg::CORDIC_FRAC - TRIG_BITS;
    localparam int IW    = $clog2(TRIG_BITS + 1);
    localparam int TW    = TRIG_BITS + 2;
    localparam int FW    = 50;
    localparam int PW    = FW + TW;
    localparam int SW    = PW - TRIG_BITS;
    localparam int AW    = ((POS_WIDTH > SW) ? POS_WIDTH : SW) + 2;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ROT  = 6'b000100,
        ST_PROD = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic signed [16:0]  dsum_reg;
    logic signed [16:0]  ddif_reg;
    logic signed [FW-1:0] fwd_reg;
    logic signed [FW-1:0] rot_reg;
    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic signed [CW-1:0] cz_reg;
    logic                 flip_reg;
    logic [IW-1:0]        iter_reg;
    logic signed [PW-1:0] px_reg;
    logic signed [PW-1:0] py_reg;
    logic signed [POS_WIDTH-1:0] acc_x_reg;
    logic signed [POS_WIDTH-1:0] acc_y_reg;
    logic [31:0]          acc_h_reg;

    logic [31:0]          mid;
    logic [IW-1:0]        idx;
    logic signed [CW-1:0] z0;
    logic signed [CW-1:0] atan_v;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] fx;
    logic signed [CW-1:0] fy;
    logic signed [TW-1:0] cos_q;
    logic signed [TW-1:0] sin_q;
    logic signed [SW-1:0] dx;
    logic signed [SW-1:0] dy;

    function automatic logic signed [POS_WIDTH-1:0] sat_add(
        input logic signed [POS_WIDTH-1:0] a,
        input logic signed [SW-1:0]        b
    );
        logic signed [AW-1:0] s;
        logic signed [AW-1:0] mx;
        logic signed [AW-1:0] mn;
        logic signed [POS_WIDTH-1:0] r;
        s  = AW'(a) + AW'(b);
        mx = AW'({1'b0, {(POS_WIDTH-1){1'b1}}});
        mn = AW'(signed'({1'b1, {(POS_WIDTH-1){1'b0}}}));
        if (s > mx) begin
            r = mx[POS_WIDTH-1:0];
        end else if (s < mn) begin
            r = mn[POS_WIDTH-1:0];
        end else begin
            r = s[POS_WIDTH-1:0];
        end
        return r;
    endfunction

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign pos_x     = acc_x_reg;
    assign pos_y     = acc_y_reg;
    assign heading   = acc_h_reg;

    always_comb begin
        mid    = acc_h_reg + rot_reg[32:1];
        z0     = CW'(signed'(mid));
        idx    = iter_reg - IW'(1);
        atan_v = CW'(ddo_pkg::atan_lookup(5'(idx)));
        xs     = cx_reg >>> idx;
        ys     = cy_reg >>> idx;
        fx     = flip_reg ? -cx_reg : cx_reg;
        fy     = flip_reg ? -cy_reg : cy_reg;
        cos_q  = TW'((fx + CW'(1 << (SH - 1))) >>> SH);
        sin_q  = TW'((fy + CW'(1 << (SH - 1))) >>> SH);
        dx     = SW'((px_reg + PW'(1 << (TRIG_BITS - 1))) >>> TRIG_BITS);
        dy     = SW'((py_reg + PW'(1 << (TRIG_BITS - 1))) >>> TRIG_BITS);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (cmd_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_ROT;
            ST_ROT:  if (iter_reg == IW'(TRIG_BITS)) state_next = ST_PROD;
            ST_PROD: state_next = ST_ACC;
            ST_ACC:  state_next = ST_OUT;
            ST_OUT:  if (res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_h_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_ACC) begin
                acc_x_reg <= sat_add(acc_x_reg, dx);
                acc_y_reg <= sat_add(acc_y_reg, dy);
                acc_h_reg <= acc_h_reg + rot_reg[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                dsum_reg <= cmd.dsum;
                ddif_reg <= cmd.ddif;
            end
            ST_MUL: begin
                fwd_reg  <= FW'(dsum_reg) * FW'($signed({1'b0, forward_gain}));
                rot_reg  <= FW'(ddif_reg) * FW'($signed({1'b0, rotate_gain}));
                iter_reg <= '0;
            end
            ST_ROT: begin
                if (iter_reg == '0) begin
                    cx_reg <= ddo_pkg::CORDIC_K;
                    cy_reg <= '0;
                    iter_reg <= IW'(1);
                    if (z0 > CW'(1 << 30)) begin
                        cz_reg <= z0 - CW'(64'sd1 << 31);
                        flip_reg <= 1'b1;
                    end else if (z0 < -CW'(1 << 30)) begin
                        cz_reg <= z0 + CW'(64'sd1 << 31);
                        flip_reg <= 1'b1;
                    end else begin
                        cz_reg <= z0;
                        flip_reg <= 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        if (state_reg == ST_ROT && iter_reg != '0) begin
            // iter_reg counts one ahead of the CORDIC step index.
            iter_reg <= iter_reg + IW'(1);
            if (!cz_reg[CW-1]) begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - atan_v;
            end else begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + atan_v;
            end
        end
        if (state_reg == ST_PROD) begin
            px_reg <= fwd_reg * cos_q;
            py_reg <= fwd_reg * sin_q;
        end
    end

endmodule

### rtl/core/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// Differential drive odometry
// Integrates wheel encoder counts into an x, y, heading pose.
// ----------------------------------------------------------------------------
// Each input beat carries raw 16-bit right and left encoder counters; the
// first beat after reset latches them and reports a zero pose. Every beat
// yields one pose beat. The pose engine runs an iterative CORDIC that
// performs one rotation step per cycle and takes a new item only after the
// pose for the last one has been accepted; a two-entry queue lets the front
// end accept beats while the engine works.
module differential_drive_odometry #(
    parameter int POS_WIDTH = ddo_pkg::POS_WIDTH_DEF,
    parameter int TRIG_BITS = ddo_pkg::TRIG_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // right_count, left_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((2*POS_WIDTH+32+7)/8)*8-1:0] m_tdata  // pos_x, pos_y, heading
);

    localparam int OW = ((2*POS_WIDTH+32+7)/8)*8;

    logic [31:0] fwd_gain_reg;
    logic [31:0] rot_gain_reg;
    logic              f_valid;
    logic              f_ready;
    ddo_pkg::ddo_cmd_t f_cmd;
    logic              q_valid;
    logic              q_ready;
    ddo_pkg::ddo_cmd_t q_cmd;
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [31:0]          heading;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_gain_reg <= ddo_pkg::FWD_GAIN_RESET;
            rot_gain_reg <= ddo_pkg::ROT_GAIN_RESET;
        end else if (cfg_we) begin
            if (cfg_index == ddo_pkg::REG_FWD_GAIN) begin
                fwd_gain_reg <= cfg_data;
            end else begin
                rot_gain_reg <= cfg_data;
            end
        end
    end

    ddo_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .right_count(s_tdata[15:0]), .left_count(s_tdata[31:16]),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    ddo_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    ddo_back #(.POS_WIDTH(POS_WIDTH), .TRIG_BITS(TRIG_BITS)) u_back (
        .aclk, .aresetn,
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .forward_gain(fwd_gain_reg), .rotate_gain(rot_gain_reg),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .pos_x, .pos_y, .heading
    );

    assign m_tdata = OW'({heading, pos_y, pos_x});

endmodule

### bench/differential_drive_odometry_test.sv
// ----------------------------------------------------------------------------
// Differential drive odometry testbench
// Streams encoder count beats into the odometry block and checks every pose
// beat against a cycle-free predictor of the pose integration, over several
// gain settings and both idle and back-pressure patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module differential_drive_odometry_test;

    localparam int  POS_W       = 48;
    localparam int  TRIG_W      = 16;
    localparam int  ROUND_SHIFT = ddo_pkg::CORDIC_FRAC - TRIG_W;
    localparam int  NUM_PHASES  = 6;
    localparam int  RAND_ITEMS  = 215;
    localparam int  DRAIN_WAIT  = 60;
    localparam longint CYCLE_LIMIT = 400000;

    localparam logic [31:0] ARCTAN [0:15] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef struct packed {
        logic [31:0]             hd;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } pose_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_index = ddo_pkg::REG_FWD_GAIN;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;    // right_count, left_count
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;         // pos_x, pos_y, heading

    logic [31:0] count_q [$];
    pose_t       pose_q [$];
    int          send_idle = 0;
    int          recv_idle = 0;
    int          errors = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    longint      cycles = 0;

    logic [31:0] fwd_gain = ddo_pkg::FWD_GAIN_RESET;
    logic [31:0] rot_gain = ddo_pkg::ROT_GAIN_RESET;
    logic [15:0] last_r, last_l;
    logic        latched = 1'b0;
    longint      odo_x, odo_y;
    logic [31:0] odo_hd;

    differential_drive_odometry dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic void cordic_cos_sin(input logic [31:0] ang, output longint c,
                                           output longint s);
        longint z, x, y, nx;
        bit flip;
        z = longint'($signed(ang));
        x = longint'(ddo_pkg::CORDIC_K);
        y = 0;
        flip = 0;
        if (z > (64'sd1 <<< 30)) begin
            z -= 64'sd1 <<< 31;
            flip = 1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z += 64'sd1 <<< 31;
            flip = 1;
        end
        for (int i = 0; i < TRIG_W; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(ARCTAN[i]);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(ARCTAN[i]);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = (x + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        s = (y + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    endfunction

    function automatic longint scale_round(input longint f, input longint t);
        logic signed [95:0] fw, tw, p;
        fw = f;
        tw = t;
        p = fw * tw + (96'sd1 <<< (TRIG_W - 1));
        return longint'(p >>> TRIG_W);
    endfunction

    function automatic longint clamp_add(input longint a, input longint b);
        longint mx, mn, r;
        mx = (64'sd1 <<< (POS_W - 1)) - 1;
        mn = -mx - 1;
        r = a + b;
        if (r > mx) return mx;
        if (r < mn) return mn;
        return r;
    endfunction

    task automatic advance_pose(input logic [31:0] beat);
        logic [15:0] r, l, dr16, dl16;
        longint dr, dl, fwd, rot, c, s, half_rot;
        logic [31:0] mid;
        r = beat[15:0];
        l = beat[31:16];
        if (!latched) begin
            last_r = r;
            last_l = l;
            odo_x = 0;
            odo_y = 0;
            odo_hd = '0;
            latched = 1'b1;
        end
        dr16 = r - last_r;
        dl16 = l - last_l;
        dr = longint'($signed(dr16));
        dl = longint'($signed(dl16));
        fwd = (dr + dl) * longint'(fwd_gain);
        rot = (dr - dl) * longint'(rot_gain);
        half_rot = rot >>> 1;
        mid = odo_hd + half_rot[31:0];
        cordic_cos_sin(mid, c, s);
        odo_x = clamp_add(odo_x, scale_round(fwd, c));
        odo_y = clamp_add(odo_y, scale_round(fwd, s));
        odo_hd = odo_hd + rot[31:0];
        last_r = r;
        last_l = l;
        pose_q.push_back('{x: odo_x[POS_W-1:0], y: odo_y[POS_W-1:0], hd: odo_hd});
    endtask

    task automatic report_mismatch(input string field, input longint want,
                                   input longint got);
        $display("beat %0d: %s mismatch, expected %0d, got %0d", beats_out, field,
                 want, got);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                advance_pose(s_tdata);
                beats_in++;
            end
            if (count_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                s_tvalid <= 1'b1;
                s_tdata <= count_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        pose_t want, got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                beats_out++;
                if (pose_q.size() == 0) begin
                    $display("beat %0d: pose beat with nothing expected", beats_out);
                    errors++;
                end else begin
                    want = pose_q.pop_front();
                    if (got.x !== want.x) report_mismatch("pos_x", want.x, got.x);
                    if (got.y !== want.y) report_mismatch("pos_y", want.y, got.y);
                    if (got.hd !== want.hd)
                        report_mismatch("heading", $signed(want.hd), $signed(got.hd));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_gains(input logic [31:0] fg, input logic [31:0] rg);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= ddo_pkg::REG_FWD_GAIN;
        cfg_data <= fg;
        @(posedge aclk);
        cfg_index <= ddo_pkg::REG_ROT_GAIN;
        cfg_data <= rg;
        @(posedge aclk);
        cfg_we <= 1'b0;
        fwd_gain = fg;
        rot_gain = rg;
    endtask

    task automatic drain();
        wait (count_q.size() == 0 && !s_tvalid && pose_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] cur_r, cur_l, dr, dl;
        int kind;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // First beat only latches; then full-scale forward, reverse, wraps and spins.
        count_q.push_back({16'h0000, 16'hFFFF});
        count_q.push_back({16'h7FFF, 16'h7FFE});
        count_q.push_back({16'hFFFF, 16'hFFFE});
        count_q.push_back({16'h7FFF, 16'h7FFE});
        count_q.push_back({16'h7FFF, 16'h7FFE});
        count_q.push_back({16'hFFFF, 16'h7FFE});
        count_q.push_back({16'h7FFF, 16'hFFFE});
        count_q.push_back({16'h0000, 16'h0000});
        count_q.push_back({16'hFFFF, 16'h0001});
        count_q.push_back({16'h0001, 16'hFFFF});
        count_q.push_back({16'h0001, 16'hFFFF});
        count_q.push_back({16'h8001, 16'h7FFF});
        count_q.push_back({16'h0000, 16'h0000});
        cur_r = 16'h0000;
        cur_l = 16'h0000;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1: write_gains(32'h0000_0000, 32'h0000_0000);
                2: write_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: write_gains($urandom, $urandom);
                4: write_gains(32'h0010_0000, $urandom_range(32'h0100_0000));
                5: write_gains($urandom, $urandom);
                default: ;
            endcase
            send_idle = (ph % 3 == 0) ? 17 : (ph % 3 == 1) ? 85 : 0;
            recv_idle = (ph % 3 == 0) ? 85 : (ph % 3 == 1) ? 17 : 0;
            for (int n = 0; n < RAND_ITEMS; n++) begin
                kind = $urandom_range(99);
                if (kind < 65) begin
                    dr = 16'($urandom_range(600) - 300);
                    dl = 16'($urandom_range(600) - 300);
                end else if (kind < 80) begin
                    dr = 16'($urandom);
                    dl = 16'($urandom);
                end else if (kind < 92) begin
                    dr = 16'($urandom_range(4000) - 2000);
                    dl = -dr;
                end else begin
                    dr = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                    dl = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                end
                cur_r += dr;
                cur_l += dl;
                count_q.push_back({cur_l, cur_r});
            end
            drain();
        end

        $display("covered %0d count beats and %0d pose beats over %0d gain settings",
                 beats_in, beats_out, NUM_PHASES);
        $display("gains included zero, full scale and random, with saturating travel");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
